>>> src/rrs_pkg.sv
// Shared types and constants of the round-robin schedule simulator.
package rrs_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int IDX_W      = $clog2(MAX_PROCS);
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int DATA_W     = 16;
  localparam int TIME_W     = 21;
  localparam int SUM_W      = 25;
  localparam int OUT_IDX_W  = 4;
  localparam int ENTRY_W    = 3 * DATA_W;
  localparam int IN_TDATA_W = 2 * DATA_W;
  localparam int RES_W      = OUT_IDX_W + DATA_W + 3 * TIME_W + 2 * SUM_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_QUANTUM_ADDR = 2'd0;
  localparam logic [DATA_W-1:0]     QUANTUM_RESET    = 16'd4;

  // One table entry as held in the job RAM.
  typedef struct packed {
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] burst;
    logic [DATA_W-1:0] arrival;
  } entry_t;

  // One completion record; the last member lands in the lowest bits.
  typedef struct packed {
    logic [SUM_W-1:0]     sum_turnaround;
    logic [SUM_W-1:0]     sum_waiting;
    logic [TIME_W-1:0]    waiting;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    finish_time;
    logic [DATA_W-1:0]    job_burst;
    logic [OUT_IDX_W-1:0] job_index;
  } result_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic rd_cur;
    logic exec;
    logic advance;
    logic fin;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic job_done;
    logic last_left;
    logic out_free;
  } status_t;

endpackage

>>> src/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rrs_ctrl.sv
// Sequencer that loads jobs and steps the round-robin walk.
module rrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  rrs_pkg::status_t sts_i,
  output rrs_pkg::cmd_t    cmd_o
);
  import rrs_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_EXEC,
    ST_NEXT,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.advance = 1'b1;
        state_d       = sts_i.job_done ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = sts_i.last_left ? ST_LOAD : ST_READ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/rrs_dp.sv
// Datapath: job RAM, pending bits, simulated clock, cursor and result stage.
module rrs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrs_pkg::cmd_t                 cmd_i,
  output rrs_pkg::status_t              sts_o,
  input  logic [rrs_pkg::DATA_W-1:0]    quantum_i,
  input  logic [rrs_pkg::DATA_W-1:0]    in_arrival_i,
  input  logic [rrs_pkg::DATA_W-1:0]    in_burst_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rrs_pkg::result_t              out_res_o,
  output logic                          out_final_o
);
  import rrs_pkg::*;

  logic [CNT_W-1:0]     loaded_q, loaded_d, loaded_inc;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [IDX_W-1:0]     cursor_q, cursor_d, cursor_nxt;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic [TIME_W-1:0]    turn_q, turn_d;
  logic [DATA_W-1:0]    arr_q, arr_d, bur_q, bur_d;
  logic [SUM_W-1:0]     wsum_q, wsum_d, tsum_q, tsum_d;
  logic [MAX_PROCS-1:0] pend_q, pend_d;
  logic                 ran_q, ran_d, done_q, done_d;
  logic                 out_valid_q, out_valid_d, out_final_q, out_final_d;
  result_t              out_res_q, out_res_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  entry_t               ram_wdata, rd;

  logic [DATA_W-1:0]    q_eff, slice, rem_new;
  logic [TIME_W-1:0]    t_start, wait_val;
  logic                 loaded_room, out_free, at_last;

  assign loaded_room = (loaded_q < CNT_W'(MAX_PROCS));
  assign loaded_inc  = loaded_room ? loaded_q + CNT_W'(1) : loaded_q;
  assign q_eff       = (quantum_i == '0) ? DATA_W'(1) : quantum_i;
  assign slice       = (rd.remaining < q_eff) ? rd.remaining : q_eff;
  assign rem_new     = rd.remaining - slice;
  assign t_start     = (TIME_W'(rd.arrival) > time_q) ? TIME_W'(rd.arrival) : time_q;
  assign cursor_nxt  = cursor_q + IDX_W'(1);
  assign at_last     = ({1'b0, cursor_q} == n_q - CNT_W'(1));
  assign wait_val    = turn_q - TIME_W'(bur_q);
  assign out_free    = !out_valid_q || out_ready_i;

  // RAM write: table fill during loading, remaining work during a visit.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_q;
    ram_wdata = rd;
    ram_raddr = cursor_q;
    if (cmd_i.load) begin
      ram_we    = loaded_room;
      ram_waddr = loaded_q[IDX_W-1:0];
      ram_wdata = '{remaining: in_burst_i, burst: in_burst_i, arrival: in_arrival_i};
    end else if (cmd_i.exec) begin
      ram_we              = pend_q[cursor_q];
      ram_wdata.remaining = rem_new;
      // Fetch the following entry to decide where the cursor goes.
      ram_raddr           = cursor_nxt;
    end
  end

  rrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  always_comb begin
    loaded_d    = loaded_q;
    n_d         = n_q;
    left_d      = left_q;
    cursor_d    = cursor_q;
    idx_d       = idx_q;
    time_d      = time_q;
    turn_d      = turn_q;
    arr_d       = arr_q;
    bur_d       = bur_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    pend_d      = pend_q;
    ran_d       = ran_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_final_d = out_final_q;
    out_res_d   = out_res_q;

    if (cmd_i.load) begin
      loaded_d = loaded_inc;
      if (loaded_room) begin
        pend_d[loaded_q[IDX_W-1:0]] = 1'b1;
      end
      if (cmd_i.start) begin
        loaded_d = '0;
        n_d      = loaded_inc;
        left_d   = loaded_inc;
        cursor_d = '0;
        time_d   = '0;
        wsum_d   = '0;
        tsum_d   = '0;
        ran_d    = 1'b0;
      end
    end

    if (cmd_i.exec) begin
      done_d = 1'b0;
      idx_d  = cursor_q;
      arr_d  = rd.arrival;
      bur_d  = rd.burst;
      if (pend_q[cursor_q]) begin
        time_d = t_start + TIME_W'(slice);
        ran_d  = 1'b1;
        if (rem_new == '0) begin
          pend_d[cursor_q] = 1'b0;
          done_d           = 1'b1;
        end
      end
    end

    if (cmd_i.advance) begin
      turn_d = time_q - TIME_W'(arr_q);
      // An idle pass steps forward so time can jump to the next arrival.
      if (at_last) begin
        cursor_d = '0;
        ran_d    = 1'b0;
      end else if (TIME_W'(rd.arrival) <= time_q) begin
        cursor_d = cursor_nxt;
      end else if (ran_q) begin
        cursor_d = '0;
        ran_d    = 1'b0;
      end else begin
        cursor_d = cursor_nxt;
      end
    end

    if (cmd_i.fin) begin
      left_d      = left_q - CNT_W'(1);
      wsum_d      = wsum_q + SUM_W'(wait_val);
      tsum_d      = tsum_q + SUM_W'(turn_q);
      done_d      = 1'b0;
      out_valid_d = 1'b1;
      out_final_d = (left_q == CNT_W'(1));
      out_res_d   = '{sum_turnaround: tsum_q + SUM_W'(turn_q),
                      sum_waiting:    wsum_q + SUM_W'(wait_val),
                      waiting:        wait_val,
                      turnaround:     turn_q,
                      finish_time:    time_q,
                      job_burst:      bur_q,
                      job_index:      OUT_IDX_W'(idx_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      n_q         <= '0;
      left_q      <= '0;
      cursor_q    <= '0;
      time_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      pend_q      <= '0;
      ran_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_final_q <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      n_q         <= n_d;
      left_q      <= left_d;
      cursor_q    <= cursor_d;
      time_q      <= time_d;
      wsum_q      <= wsum_d;
      tsum_q      <= tsum_d;
      pend_q      <= pend_d;
      ran_q       <= ran_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      out_final_q <= out_final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    turn_q    <= turn_d;
    arr_q     <= arr_d;
    bur_q     <= bur_d;
    out_res_q <= out_res_d;
  end

  assign sts_o.job_done  = done_q;
  assign sts_o.last_left = (left_q == CNT_W'(1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_final_o = out_final_q;

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= n_q)
    else $error("jobs left exceeds jobs in the set");

  a_cursor_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != '0) |-> ({1'b0, cursor_q} < n_q))
    else $error("cursor outside the loaded set");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> (cursor_q == '0 && time_q == '0 && loaded_q == '0))
    else $error("simulation start did not clear the walk state");

  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_cur |-> (left_q != '0))
    else $error("job fetch outside a walk");

  a_fin_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (done_q && out_free))
    else $error("result issued without a completed job or a free slot");

  a_final_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && left_q == CNT_W'(1)) |=> (left_q == '0 && pend_q == '0))
    else $error("last result issued with jobs still pending");

endmodule

>>> src/round_robin_schedule_sim_core.sv
// Top level of the round-robin schedule simulator with its register port.
//
// Jobs enter on the s_axis channel, one request per cycle while s_axis_tready
// is high: tdata carries the arrival tick and the burst length, tlast marks
// the final job of a set. Up to MAX_PROCS jobs are kept; further jobs of a
// set are dropped. The request with tlast set starts the walk, and
// s_axis_tready stays low until the last completion of the set has been
// handed to the output register. Each visit to a job fetches its entry,
// runs a slice and fetches the following entry to move the cursor, and each
// completed job then issues its result; the single-port read of the job RAM
// sets this pace. Results leave on m_axis in completion order, tlast set on
// the last result of the set. A stalled m_axis_tready holds the walk at the
// next completion.
// Reset empties the job table, clears the totals and sets the quantum
// register (byte address 0) to 4; a quantum of 0 acts as 1.
module round_robin_schedule_sim_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rrs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  // Job requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // arrival_time, burst_time
  input  logic                               s_axis_tlast,  // last_job
  // Completion results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // job_index, job_burst, finish_time, turnaround, waiting, sum_waiting,
  // sum_turnaround, zero fill
  output logic [rrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast   // final_result
);
  import rrs_pkg::*;

  logic [DATA_W-1:0] quantum_q, quantum_d;
  cmd_t              cmd;
  status_t           sts;
  result_t           res;
  logic              in_ready;

  assign pready = 1'b1;

  always_comb begin
    quantum_d = quantum_q;
    if (psel && penable && pwrite && pready && (paddr == REG_QUANTUM_ADDR)) begin
      quantum_d = pwdata[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else begin
      quantum_q <= quantum_d;
    end
  end

  assign prdata = (paddr == REG_QUANTUM_ADDR) ? APB_DATA_W'(quantum_q) : '0;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .quantum_i    (quantum_q),
    .in_arrival_i (s_axis_tdata[DATA_W-1:0]),
    .in_burst_i   (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res),
    .out_final_o  (m_axis_tlast)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = OUT_TDATA_W'(res);

endmodule
